FILE: rtl/core/text_terminal_cursor_control_unit_defines.svh
// Assertion macros used by the terminal cursor control RTL.
`ifndef TEXT_TERMINAL_CURSOR_CONTROL_UNIT_DEFINES_SVH
`define TEXT_TERMINAL_CURSOR_CONTROL_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TTCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ttcc assertion failed");

// Next-cycle implication, checked outside reset.
`define TTCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ttcc assertion failed");

`endif

FILE: rtl/core/ttcc_pkg.sv
// Types, constants and the tab stop table of the terminal cursor control unit.
package ttcc_pkg;

  localparam int unsigned ColW     = 8;
  localparam int unsigned RowW     = 8;
  localparam int unsigned FontW    = 6;
  localparam int unsigned ScrollW  = 14;
  localparam int unsigned CharW    = 8;
  localparam int unsigned StopW    = ColW + 1;
  localparam int unsigned ColCount = 2 ** ColW;
  localparam int unsigned TabStop  = 5;

  localparam logic [ColW-1:0]  ColsReset = 8'd80;
  localparam logic [RowW-1:0]  RowsReset = 8'd25;
  localparam logic [FontW-1:0] FontReset = 6'd8;

  localparam logic [CharW-1:0] ChBell = 8'h07;
  localparam logic [CharW-1:0] ChBs   = 8'h08;
  localparam logic [CharW-1:0] ChTab  = 8'h09;
  localparam logic [CharW-1:0] ChNl   = 8'h0A;
  localparam logic [CharW-1:0] ChVt   = 8'h0B;
  localparam logic [CharW-1:0] ChFf   = 8'h0C;
  localparam logic [CharW-1:0] ChCr   = 8'h0D;

  typedef enum logic [1:0] {
    CfgScreenColumns = 2'd0,
    CfgScreenRows    = 2'd1,
    CfgFontHeight    = 2'd2
  } ttcc_cfg_idx_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             draw_enable;
  } ttcc_in_t;

  typedef struct packed {
    logic               draw_valid;
    logic [CharW-1:0]   glyph;
    logic [ColW-1:0]    draw_col;
    logic [RowW-1:0]    draw_row;
    logic [ScrollW-1:0] scroll_lines;
    logic [ColW-1:0]    cursor_col;
    logic [RowW-1:0]    cursor_row;
  } ttcc_out_t;

  typedef struct packed {
    logic [ColW-1:0]  screen_columns;
    logic [RowW-1:0]  screen_rows;
    logic [FontW-1:0] font_height;
  } ttcc_cfg_t;

  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
  } ttcc_cursor_t;

  typedef logic [ColCount-1:0][StopW-1:0] ttcc_tab_lut_t;

  // Next tab stop for every column value.
  function automatic ttcc_tab_lut_t build_tab_lut();
    ttcc_tab_lut_t lut;
    for (int i = 0; i < ColCount; i++) begin
      lut[i] = StopW'(i + TabStop - (i % TabStop));
    end
    return lut;
  endfunction

  localparam ttcc_tab_lut_t TabLut = build_tab_lut();

endpackage

FILE: rtl/core/ttcc_cursor_next.sv
// Combinational cursor update: decodes one character against the current cursor.
module ttcc_cursor_next (
  input  ttcc_pkg::ttcc_in_t     item_i,
  input  ttcc_pkg::ttcc_cursor_t cursor_i,
  input  ttcc_pkg::ttcc_cfg_t    cfg_i,
  output ttcc_pkg::ttcc_out_t    result_o
);
  import ttcc_pkg::*;

  logic [ColW-1:0]    eff_cols;
  logic [RowW-1:0]    eff_rows;
  logic [RowW:0]      row_inc;
  logic               row_wrap;
  logic [RowW-1:0]    adv_row;
  logic [ScrollW-1:0] adv_scroll;
  logic [ColW:0]      col_inc;
  logic               col_wrap;
  logic [StopW-1:0]   tab_stop;
  logic               tab_fit;
  logic [ScrollW-1:0] ff_scroll;

  // A zero window size acts as one.
  assign eff_cols = (cfg_i.screen_columns == '0) ? ColW'(1) : cfg_i.screen_columns;
  assign eff_rows = (cfg_i.screen_rows == '0) ? RowW'(1) : cfg_i.screen_rows;

  assign row_inc    = {1'b0, cursor_i.row} + (RowW+1)'(1);
  assign row_wrap   = row_inc >= {1'b0, eff_rows};
  assign adv_row    = row_wrap ? eff_rows - RowW'(1) : row_inc[RowW-1:0];
  assign adv_scroll = row_wrap ? ScrollW'(cfg_i.font_height) + ScrollW'(1) : '0;

  assign col_inc  = {1'b0, cursor_i.col} + (ColW+1)'(1);
  assign col_wrap = col_inc >= {1'b0, eff_cols};

  assign tab_stop = TabLut[cursor_i.col];
  assign tab_fit  = tab_stop < StopW'(eff_cols);

  assign ff_scroll = ScrollW'(cfg_i.font_height) * ScrollW'(eff_rows);

  always_comb begin
    result_o            = '0;
    result_o.cursor_col = cursor_i.col;
    result_o.cursor_row = cursor_i.row;
    case (item_i.char_code)
      ChBell: begin
      end
      ChBs: begin
        if (cursor_i.col != '0) begin
          result_o.cursor_col = cursor_i.col - ColW'(1);
        end
      end
      ChTab: begin
        if (tab_fit) begin
          result_o.cursor_col = tab_stop[ColW-1:0];
        end else begin
          result_o.cursor_col   = '0;
          result_o.cursor_row   = adv_row;
          result_o.scroll_lines = adv_scroll;
        end
      end
      ChFf: begin
        result_o.cursor_row   = '0;
        result_o.scroll_lines = ff_scroll;
      end
      ChVt: begin
        result_o.cursor_row   = adv_row;
        result_o.scroll_lines = adv_scroll;
      end
      ChNl: begin
        result_o.cursor_col   = '0;
        result_o.cursor_row   = adv_row;
        result_o.scroll_lines = adv_scroll;
      end
      ChCr: begin
        result_o.cursor_col = '0;
      end
      default: begin
        // Printable: draw at the old cursor when draw_enable is set, then advance and wrap.
        if (item_i.draw_enable) begin
          result_o.draw_valid = 1'b1;
          result_o.glyph      = item_i.char_code;
          result_o.draw_col   = cursor_i.col;
          result_o.draw_row   = cursor_i.row;
        end
        if (col_wrap) begin
          result_o.cursor_col   = '0;
          result_o.cursor_row   = adv_row;
          result_o.scroll_lines = adv_scroll;
        end else begin
          result_o.cursor_col = col_inc[ColW-1:0];
        end
      end
    endcase
  end

endmodule

FILE: rtl/core/text_terminal_cursor_control_unit.sv
// Flow: a transaction accepted into the input register is decoded by the cursor
// update logic and moves to the result register once the output is not stalled.
// Throughput: one character per cycle while the output is not stalled; the input
// register, the cursor update logic and the result register run in one pass, and
// the cursor registers carry the updated cursor from one character to the next.
// Reset: cursor returns to column 0, row 0; window 80 x 25, font height 8;
// both pipeline stages empty. Configuration writes are always ready.
module text_terminal_cursor_control_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ttcc_pkg::ttcc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ttcc_pkg::ttcc_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import ttcc_pkg::*;
  `include "text_terminal_cursor_control_unit_defines.svh"

  logic         s1_valid_q, s1_valid_d;
  ttcc_in_t     s1_data_q;
  logic         out_valid_q, out_valid_d;
  ttcc_out_t    out_data_q;
  ttcc_cursor_t cur_q, cur_d;
  ttcc_cfg_t    cfg_q, cfg_d;
  ttcc_out_t    result;
  logic         out_busy;
  logic         s1_adv;
  logic         in_acc;
  logic         cfg_acc;

  ttcc_cursor_next u_next (
    .item_i   (s1_data_q),
    .cursor_i (cur_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  assign out_busy   = out_valid_q && out_stall_i;
  assign s1_adv     = s1_valid_q && !out_busy;
  assign in_stall_o = s1_valid_q && out_busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    // Hold the result while stalled, drop it once taken.
    out_valid_d = s1_adv || out_busy;

    cur_d = cur_q;
    if (s1_adv) begin
      cur_d.col = result.cursor_col;
      cur_d.row = result.cursor_row;
    end

    cfg_d = cfg_q;
    if (cfg_acc) begin
      case (ttcc_cfg_idx_e'(cfg_index_i))
        CfgScreenColumns: cfg_d.screen_columns = cfg_data_i;
        CfgScreenRows:    cfg_d.screen_rows    = cfg_data_i;
        CfgFontHeight:    cfg_d.font_height    = cfg_data_i[FontW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q           <= 1'b0;
      out_valid_q          <= 1'b0;
      cur_q                <= '0;
      cfg_q.screen_columns <= ColsReset;
      cfg_q.screen_rows    <= RowsReset;
      cfg_q.font_height    <= FontReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q <= result;
    end
  end

  `TTCC_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_q)
  `TTCC_ASSERT_NOW(a_stall_needs_item, in_stall_o, s1_valid_q)
  `TTCC_ASSERT_NEXT(a_cursor_holds, !s1_adv, cur_q == $past(cur_q))
  `TTCC_ASSERT_NOW(a_nodraw_zero, out_valid_q && !out_data_q.draw_valid,
                   out_data_q.glyph == '0 && out_data_q.draw_col == '0 &&
                   out_data_q.draw_row == '0)
  `TTCC_ASSERT_NOW(a_out_matches_cursor, out_valid_q && !s1_valid_q,
                   out_data_q.cursor_col == cur_q.col && out_data_q.cursor_row == cur_q.row)

endmodule
